// ===== hw/rtl/slrng_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Package for the shuffled Lehmer uniform generator.
// It holds the shared data type, the generator constants and the sequencer states.
// It has no dependencies.

package slrng_pkg;

	localparam int DATA_W = 31;

	typedef logic [DATA_W-1:0] data_t;

	// Multiplier and Mersenne prime modulus of the minimal-standard generator.
	localparam logic [14:0] LEHMER_MULT = 15'd16807;
	localparam data_t LEHMER_MOD = 31'h7FFF_FFFF;

	// Largest value handed out. It matches the 1 - 1.2e-7 clamp of the floating form.
	localparam data_t SAMPLE_MAX = 31'd2147483389;

	localparam int WARMUP_STEPS = 8;
	localparam int DEF_TABLE_DEPTH = 32;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_RB_MUL,
		ST_RB_RED,
		ST_DR_MUL,
		ST_DR_DIV,
		ST_DR_READ,
		ST_DR_SWAP
	} slrng_state_t;

endpackage : slrng_pkg

`default_nettype wire

// ===== hw/rtl/slrng_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Request channel of the shuffled Lehmer generator: valid, ready and the restart flag.
// It has no dependencies.

interface slrng_req_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink (input valid, input restart, output ready);
endinterface : slrng_req_if

`default_nettype wire

// ===== hw/rtl/slrng_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Response channel of the shuffled Lehmer generator: valid, ready and the sample.
// It has no dependencies.

interface slrng_rsp_if;
	logic valid;
	logic ready;
	logic [30:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface : slrng_rsp_if

`default_nettype wire

// ===== hw/rtl/slrng_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Generic single-port synchronous RAM with a registered read.
// It has no dependencies.

module slrng_ram #(
	parameter int WIDTH = 31,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end

endmodule : slrng_ram

`default_nettype wire

// ===== hw/rtl/slrng_lehmer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// One step of the minimal-standard generator: x * 16807 mod (2^31 - 1).
// The product is registered; the Mersenne fold and final correction follow it.
// Depends on slrng_pkg.

module slrng_lehmer
	import slrng_pkg::*;
(
	input  wire logic  clk,
	input  wire data_t x,
	output data_t      y
);

	logic [45:0] prod_s1;
	logic [31:0] fold;

	always_ff @(posedge clk) begin
		prod_s1 <= 46'(x) * 46'(LEHMER_MULT);
	end

	// 2^31 is 1 modulo the prime, so the high part adds onto the low part.
	assign fold = {1'b0, prod_s1[30:0]} + {17'b0, prod_s1[45:31]};

	always_comb begin
		if (fold >= {1'b0, LEHMER_MOD}) begin
			y = 31'(fold - {1'b0, LEHMER_MOD});
		end else begin
			y = fold[30:0];
		end
	end

endmodule : slrng_lehmer

`default_nettype wire

// ===== hw/rtl/slrng_slot_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Slot selection: the previous draw divided by 1 + (2^31 - 2) / depth, wrapped to the depth.
// Reciprocal multiplication with one registered product. Depends on slrng_pkg.

module slrng_slot_div
	import slrng_pkg::*;
#(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire data_t                          dividend,
	output logic                                done,
	output logic [$clog2(TABLE_DEPTH)-1:0]      slot
);

	localparam int AW = $clog2(TABLE_DEPTH);
	// The quotient never exceeds the depth, so one bit above the address suffices.
	localparam int QW = AW + 1;
	localparam longint DIVISOR = 1 + (longint'(LEHMER_MOD) - 1) / longint'(TABLE_DEPTH);
	// With the shift set by the divisor's bit length, the rounded-up reciprocal gives the
	// exact quotient for every 31-bit dividend and fits in 32 bits.
	localparam int SHIFT = DATA_W + $clog2(DIVISOR);
	localparam longint MAGIC_FULL = ((longint'(1) << SHIFT) + DIVISOR - 1) / DIVISOR;
	localparam logic [DATA_W:0] MAGIC = (DATA_W + 1)'(MAGIC_FULL);

	logic [63:0]   prod_s1;
	logic [63:0]   quot_full;
	logic [QW-1:0] quot;
	logic          done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			prod_s1 <= 64'(dividend) * 64'(MAGIC);
		end
	end

	assign quot_full = prod_s1 >> SHIFT;
	assign quot      = quot_full[QW-1:0];
	assign done      = done_q;

	always_comb begin
		if (quot >= QW'(TABLE_DEPTH)) begin
			slot = AW'(quot - QW'(TABLE_DEPTH));
		end else begin
			slot = quot[AW-1:0];
		end
	end

endmodule : slrng_slot_div

`default_nettype wire

// ===== hw/rtl/shuffled_lehmer_uniform_rng.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Shuffled minimal-standard Lehmer uniform source with a Bays-Durham shuffle table.
// Each request transaction on req carries a restart flag and yields exactly one response
// transaction on rsp whose sample is a uniform numerator over 2^31 - 1, held to 2147483389.
// The user must write the seed register through cfg_we / cfg_wdata only while the block is
// idle; the block itself does not enforce this. An ordinary draw does not depend on
// TABLE_DEPTH: after the accepting cycle it registers the generator product and the slot
// product, waits on the slot, reads the table and swaps the entry. No new request is taken
// until the swap has committed and the block is back in idle.
// A rebuild of the table, on the first request after reset or when restart is set, loads
// the seed and then runs TABLE_DEPTH + 8 generator steps, each passing through the
// multiplier register and then the modular fold, before the draw.
// The response sits in an output register; while the receiver stalls it holds its
// transaction, and a new request may still be accepted and worked on until the next
// result needs that register, where the block waits.
// Reset clears the sequencer and sets the seed to one; the previous draw reads as zero,
// which forces a rebuild on the first request. The table itself is not cleared because
// the rebuild fills every entry before any is read.
// Depends on slrng_pkg, the two channel interfaces, slrng_ram, slrng_lehmer and
// slrng_slot_div.

module shuffled_lehmer_uniform_rng
	import slrng_pkg::*;
#(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire logic [30:0]  cfg_wdata,
	slrng_req_if.sink         req,
	slrng_rsp_if.source       rsp
);

	localparam int AW = $clog2(TABLE_DEPTH);
	// The step counter runs from TABLE_DEPTH + warm-up down to one.
	localparam int CW = $clog2(TABLE_DEPTH + WARMUP_STEPS + 1);

	slrng_state_t state_q, state_d;

	data_t          seed_q;
	data_t          gen_q;
	data_t          last_q;
	data_t          sample_q;
	logic           rsp_valid_q;
	logic [CW-1:0]  cnt_q;
	logic [CW-1:0]  cnt_m1;

	data_t          gen_next;
	data_t          seed_eff;
	data_t          ram_rdata;
	data_t          ram_wdata;
	logic [AW-1:0]  ram_addr;
	logic           ram_we;
	logic           ram_re;
	logic [AW-1:0]  slot;
	logic           div_start;
	logic           div_done;
	logic           accept;
	logic           commit;
	logic           fill_hit;

	assign accept   = req.valid && req.ready;
	assign cnt_m1   = cnt_q - 1'b1;
	assign fill_hit = cnt_m1 < CW'(TABLE_DEPTH);

	// A seed of zero, or the all-ones pattern that reduces to zero, starts from one.
	assign seed_eff = (seed_q == '0 || seed_q == LEHMER_MOD) ? data_t'(1) : seed_q;

	slrng_lehmer u_lehmer (
		.clk (clk),
		.x   (gen_q),
		.y   (gen_next)
	);

	slrng_slot_div #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_slot_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (last_q),
		.done     (div_done),
		.slot     (slot)
	);

	slrng_ram #(
		.WIDTH (DATA_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.re    (ram_re),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (req.restart || last_q == '0) begin
						state_d = ST_LOAD;
					end else begin
						state_d = ST_DR_MUL;
					end
				end
			end
			ST_LOAD:   state_d = ST_RB_MUL;
			ST_RB_MUL: state_d = ST_RB_RED;
			ST_RB_RED: begin
				if (cnt_q == CW'(1)) begin
					state_d = ST_DR_MUL;
				end else begin
					state_d = ST_RB_MUL;
				end
			end
			ST_DR_MUL: state_d = ST_DR_DIV;
			ST_DR_DIV: begin
				if (div_done) begin
					state_d = ST_DR_READ;
				end
			end
			ST_DR_READ: state_d = ST_DR_SWAP;
			ST_DR_SWAP: begin
				if (commit) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Output and datapath control.
	always_comb begin
		req.ready = 1'b0;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_addr  = slot;
		ram_wdata = gen_next;
		div_start = 1'b0;
		commit    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
			end
			ST_RB_RED: begin
				// The last TABLE_DEPTH generator outputs fill the table from the top down.
				ram_addr = cnt_m1[AW-1:0];
				ram_we   = fill_hit;
			end
			ST_DR_MUL: begin
				div_start = 1'b1;
			end
			ST_DR_READ: begin
				ram_re = 1'b1;
			end
			ST_DR_SWAP: begin
				commit = !rsp_valid_q || rsp.ready;
				ram_we = commit;
			end
			default: begin
				req.ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			seed_q      <= data_t'(1);
			gen_q       <= '0;
			last_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				seed_q <= cfg_wdata;
			end
			if (state_q == ST_LOAD) begin
				gen_q <= seed_eff;
			end else if (state_q == ST_RB_RED) begin
				gen_q <= gen_next;
				// Slot zero is written last; its value becomes the previous draw.
				if (cnt_q == CW'(1)) begin
					last_q <= gen_next;
				end
			end else if (commit) begin
				gen_q  <= gen_next;
				last_q <= ram_rdata;
			end
			if (commit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD) begin
			cnt_q <= CW'(TABLE_DEPTH + WARMUP_STEPS);
		end else if (state_q == ST_RB_RED) begin
			cnt_q <= cnt_m1;
		end
		if (commit) begin
			sample_q <= (ram_rdata > SAMPLE_MAX) ? SAMPLE_MAX : ram_rdata;
		end
	end

	assign rsp.valid  = rsp_valid_q;
	assign rsp.sample = sample_q;

endmodule : shuffled_lehmer_uniform_rng

`default_nettype wire
